>>> hw/rtl/fopa_pkg.sv
// fopa_pkg: types, codes and widths shared by the object pool allocator
// no dependencies; imported by fopa_ctrl, fopa_dp and the top level

package fopa_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 7;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam int DEFAULT_POOL_DEPTH = 64;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [1:0] STATUS_NONE_USED = 2'd2;
    localparam logic [1:0] STATUS_BAD_ADDR  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  object_address;
        logic [COUNT_W-1:0] available_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_EXEC,
        CTL_INIT
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic init_write;
        logic init_finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic init_end;
    } dp_stat_t;

endpackage

>>> hw/rtl/fopa_ctrl.sv
// fopa_ctrl: request sequencer for the object pool allocator
// depends on fopa_pkg; drives the command struct of fopa_dp

module fopa_ctrl
    import fopa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic [1:0] req_type,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd,
    output logic     busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            CTL_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = (req_type == REQ_INIT) ? CTL_INIT : CTL_EXEC;
                end
            end
            CTL_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = CTL_IDLE;
            end
            CTL_INIT:
            begin
                if (stat.init_end)
                begin
                    cmd.init_finish = 1'b1;
                    state_next      = CTL_IDLE;
                end
                else
                begin
                    cmd.init_write = 1'b1;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.exec, cmd.init_write, cmd.init_finish}))
        else $error("more than one command at once");

    a_exec_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> state_reg == CTL_IDLE && !busy)
        else $error("sequencer not idle after execute");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> busy)
        else $error("accepted item without going busy");
`endif

endmodule

>>> hw/rtl/fopa_dp.sv
// fopa_dp: slot table, stack pointers, config registers and result register
// depends on fopa_pkg; controlled by fopa_ctrl through ctl_cmd_t

module fopa_dp
    import fopa_pkg::*;
#(
    parameter int POOL_DEPTH = DEFAULT_POOL_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_t                 req,
    input  ctl_cmd_t             cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output rsp_t                 rsp
);

    localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int LINK_W = $clog2(POOL_DEPTH + 1);
    localparam int DEPTH_CAP = (POOL_DEPTH > 127) ? 127 : POOL_DEPTH;
    localparam int SPAN_W = COUNT_W + SIZE_W;
    localparam logic [LINK_W-1:0]  LINK_EMPTY = LINK_W'(POOL_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_CAP  = COUNT_W'(DEPTH_CAP);

    // slot table
    logic [ADDR_W-1:0] addr_mem [POOL_DEPTH];
    logic [LINK_W-1:0] link_mem [POOL_DEPTH];

    // configuration
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    // stacks
    logic [LINK_W-1:0]  free_top_reg, free_top_next;
    logic [LINK_W-1:0]  used_top_reg, used_top_next;
    logic [COUNT_W-1:0] free_slots_reg, free_slots_next;

    // latched item and table read data
    logic [1:0]         req_type_reg;
    logic [ADDR_W-1:0]  free_addr_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [LINK_W-1:0]  rd_link_reg;

    // init walk
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  run_addr_reg, run_addr_next;

    // result
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic [LINK_W-1:0]  rd_top;
    logic               rd_ok;
    logic [IDX_W-1:0]   rd_idx;

    logic [COUNT_W-1:0] eff_n;
    logic [COUNT_W-1:0] eff_m1;
    logic [SPAN_W-1:0]  span;
    logic [ADDR_W:0]    last_addr;
    logic               in_pool;
    logic               free_empty;
    logic               used_empty;

    logic               addr_we, link_we;
    logic [IDX_W-1:0]   wr_idx;
    logic [ADDR_W-1:0]  wr_addr;
    logic [LINK_W-1:0]  wr_link;

    assign eff_n  = (count_reg > COUNT_CAP) ? COUNT_CAP : count_reg;
    assign eff_m1 = eff_n - COUNT_W'(1);
    assign span   = SPAN_W'(eff_m1) * SPAN_W'(size_reg);
    assign last_addr = (ADDR_W + 1)'(base_reg) + (ADDR_W + 1)'(span);
    assign in_pool = (free_addr_reg != '0) && (eff_n != '0)
                     && (free_addr_reg >= base_reg)
                     && ((ADDR_W + 1)'(free_addr_reg) <= last_addr);

    assign free_empty = free_top_reg >= LINK_EMPTY;
    assign used_empty = used_top_reg >= LINK_EMPTY;

    assign rd_top = (req.req_type == REQ_FREE) ? used_top_reg : free_top_reg;
    assign rd_ok  = rd_top < LINK_EMPTY;
    assign rd_idx = IDX_W'(rd_top);

    assign stat.init_end = (cnt_reg == eff_n);

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= SIZE_W'(1);
            count_reg <= COUNT_W'(64);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_reg  <= cfg_data[ADDR_W-1:0];
                CFG_OBJECT_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_OBJECT_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // table read at accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept && rd_ok)
        begin
            rd_addr_reg <= addr_mem[rd_idx];
            rd_link_reg <= link_mem[rd_idx];
        end
    end

    // table writes
    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[wr_idx] <= wr_addr;
        end
        if (link_we)
        begin
            link_mem[wr_idx] <= wr_link;
        end
    end

    // item latch and init walk
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg  <= req.req_type;
            free_addr_reg <= req.free_address;
        end
        cnt_reg      <= cnt_next;
        run_addr_reg <= run_addr_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg   <= LINK_EMPTY;
            used_top_reg   <= LINK_EMPTY;
            free_slots_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            free_top_reg   <= free_top_next;
            used_top_reg   <= used_top_next;
            free_slots_reg <= free_slots_next;
            done_reg       <= done_next;
        end
    end

    always_comb
    begin
        free_top_next   = free_top_reg;
        used_top_next   = used_top_reg;
        free_slots_next = free_slots_reg;
        cnt_next        = cnt_reg;
        run_addr_next   = run_addr_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        addr_we         = 1'b0;
        link_we         = 1'b0;
        wr_idx          = IDX_W'(cnt_reg);
        wr_addr         = run_addr_reg;
        wr_link         = (cnt_reg == '0) ? LINK_EMPTY : LINK_W'(cnt_reg - COUNT_W'(1));

        if (cmd.accept)
        begin
            cnt_next      = '0;
            run_addr_next = base_reg;
        end

        if (cmd.init_write)
        begin
            addr_we       = 1'b1;
            link_we       = 1'b1;
            cnt_next      = cnt_reg + COUNT_W'(1);
            run_addr_next = run_addr_reg + ADDR_W'(size_reg);
        end

        if (cmd.init_finish)
        begin
            free_top_next   = (eff_n == '0) ? LINK_EMPTY : LINK_W'(eff_m1);
            used_top_next   = LINK_EMPTY;
            free_slots_next = eff_n;
            done_next       = 1'b1;
            rsp_next.status          = STATUS_OK;
            rsp_next.object_address  = '0;
            rsp_next.available_count = eff_n;
        end

        if (cmd.exec)
        begin
            done_next               = 1'b1;
            rsp_next.status         = STATUS_OK;
            rsp_next.object_address = '0;
            case (req_type_reg)
                REQ_ALLOC:
                begin
                    if (free_empty)
                    begin
                        rsp_next.status = STATUS_NO_FREE;
                    end
                    else
                    begin
                        link_we       = 1'b1;
                        wr_idx        = IDX_W'(free_top_reg);
                        wr_link       = used_top_reg;
                        free_top_next = rd_link_reg;
                        used_top_next = free_top_reg;
                        if (free_slots_reg != '0)
                        begin
                            free_slots_next = free_slots_reg - COUNT_W'(1);
                        end
                        rsp_next.object_address = rd_addr_reg;
                    end
                end
                REQ_FREE:
                begin
                    if (!in_pool)
                    begin
                        rsp_next.status = STATUS_BAD_ADDR;
                    end
                    else if (used_empty)
                    begin
                        rsp_next.status = STATUS_NONE_USED;
                    end
                    else
                    begin
                        addr_we       = 1'b1;
                        link_we       = 1'b1;
                        wr_idx        = IDX_W'(used_top_reg);
                        wr_addr       = free_addr_reg;
                        wr_link       = free_top_reg;
                        used_top_next = rd_link_reg;
                        free_top_next = used_top_reg;
                        if (free_slots_reg < COUNT_CAP)
                        begin
                            free_slots_next = free_slots_reg + COUNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
            rsp_next.available_count = free_slots_next;
        end
    end

`ifndef SYNTH
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_slots_reg <= COUNT_CAP)
        else $error("free slot count above pool depth");

    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && req_type_reg == REQ_ALLOC && !free_empty && free_slots_reg != '0
        |=> free_slots_reg == $past(free_slots_reg) - COUNT_W'(1))
        else $error("alloc did not take a free slot");

    a_init_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init_finish |=> used_top_reg == LINK_EMPTY && free_slots_reg == $past(eff_n))
        else $error("init left stacks inconsistent");

    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status != STATUS_OK |-> rsp_reg.object_address == '0)
        else $error("address returned with an error status");
`endif

endmodule

>>> hw/rtl/fixed_object_pool_allocator_top.sv
// fixed_object_pool_allocator_top: fixed-size object pool allocator
// depends on fopa_pkg, fopa_ctrl and fopa_dp
//
//  port group            direction  handshake
//  start / busy / req    in         item taken when start high and busy low
//  done / rsp            out        one cycle strobe, cannot be held off
//  cfg_wr_en / cfg_*     in         register written on any edge with cfg_wr_en
//
// alloc, free, unused: top entry read at accept; a successful alloc or free writes it
// init writes n entries, n the slot count capped at the pool depth, one entry per cycle
// the result shows on rsp with done in the cycle after the item finishes
// reset clears the stack pointers and free count; the slot table is not cleared
// the receiver cannot stall; the next item may start in the result cycle

module fixed_object_pool_allocator_top
    import fopa_pkg::*;
#(
    parameter int POOL_DEPTH = DEFAULT_POOL_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 done,
    output rsp_t                 rsp,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    fopa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    fopa_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

>>> bench/fixed_object_pool_allocator_top_test.sv
`timescale 1ns / 100ps
// fixed_object_pool_allocator_top_test: self-checking bench for the object pool allocator
// predicts every result from its own copy of the pool stacks and compares it with rsp
// depends on fopa_pkg and fixed_object_pool_allocator_top

module fixed_object_pool_allocator_top_test;
    import fopa_pkg::*;

    localparam int DEPTH = DEFAULT_POOL_DEPTH;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_GAP = 20;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    req_t                 req = '0;
    logic                 done;
    rsp_t                 rsp;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE_ADDRESS;
    logic [CFG_W-1:0]     cfg_data = '0;

    // copy of the pool state
    logic [ADDR_W-1:0]  slot_addr [DEPTH];
    int unsigned        slot_next [DEPTH];
    int unsigned        free_head = DEPTH;
    int unsigned        used_head = DEPTH;
    int unsigned        free_total = 0;
    logic [ADDR_W-1:0]  pool_base = '0;
    logic [SIZE_W-1:0]  pool_size = 16'd1;
    logic [COUNT_W-1:0] pool_count = 7'd64;

    rsp_t               pending_rsps [$];
    logic [ADDR_W-1:0]  handed_out [$];
    int                 idle_pct = 0;
    int                 errors = 0;

    fixed_object_pool_allocator_top #(
        .POOL_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .done(done),
        .rsp(rsp),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned slots_in_pool();
        return (pool_count > DEPTH) ? DEPTH : pool_count;
    endfunction

    function automatic bit addr_in_pool(input logic [ADDR_W-1:0] a);
        int unsigned n;
        logic [63:0] last;
        n = slots_in_pool();
        if (a == '0 || n == 0)
            return 1'b0;
        last = {32'b0, pool_base} + 64'(n - 1) * 64'(pool_size);
        return (a >= pool_base) && ({32'b0, a} <= last);
    endfunction

    // some address between base and the start of the last slot
    function automatic logic [ADDR_W-1:0] pick_pool_addr();
        int unsigned n;
        int unsigned span;
        logic [63:0] a;
        n = slots_in_pool();
        if (n == 0)
            return pool_base;
        span = (n - 1) * pool_size;
        if ($urandom_range(0, 1) == 0)
            a = {32'b0, pool_base} + 64'($urandom_range(0, n - 1)) * 64'(pool_size);
        else
            a = {32'b0, pool_base} + 64'($urandom_range(0, span));
        return a[ADDR_W-1:0];
    endfunction

    function automatic rsp_t pool_response(input req_t item);
        rsp_t r;
        int unsigned n;
        int unsigned i;
        int unsigned idx;
        logic [63:0] a;
        r = '0;
        r.status = STATUS_OK;
        case (item.req_type)
            REQ_INIT:
            begin
                n = slots_in_pool();
                free_head = DEPTH;
                used_head = DEPTH;
                for (i = 0; i < n; i++)
                begin
                    a = {32'b0, pool_base} + 64'(i) * 64'(pool_size);
                    slot_addr[i] = a[ADDR_W-1:0];
                    slot_next[i] = free_head;
                    free_head = i;
                end
                free_total = n;
                handed_out.delete();
            end
            REQ_ALLOC:
            begin
                if (free_head >= DEPTH)
                    r.status = STATUS_NO_FREE;
                else
                begin
                    idx = free_head;
                    free_head = slot_next[idx];
                    slot_next[idx] = used_head;
                    used_head = idx;
                    if (free_total > 0)
                        free_total--;
                    r.object_address = slot_addr[idx];
                    handed_out.push_back(slot_addr[idx]);
                end
            end
            REQ_FREE:
            begin
                if (!addr_in_pool(item.free_address))
                    r.status = STATUS_BAD_ADDR;
                else if (used_head >= DEPTH)
                    r.status = STATUS_NONE_USED;
                else
                begin
                    idx = used_head;
                    used_head = slot_next[idx];
                    slot_addr[idx] = item.free_address;
                    slot_next[idx] = free_head;
                    free_head = idx;
                    if (free_total < DEPTH)
                        free_total++;
                end
            end
            default:
            begin
            end
        endcase
        r.available_count = COUNT_W'(free_total);
        return r;
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
        req_t item;
        req_t filler;
        int gap;
        item.req_type = kind;
        item.free_address = addr;
        start <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (busy);
        pending_rsps.push_back(pool_response(item));
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            filler.req_type = 2'($urandom_range(0, 3));
            filler.free_address = ADDR_W'($urandom);
            start <= 1'b0;
            req <= filler;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure_pool(input logic [CFG_W-1:0] base_word,
                                  input logic [CFG_W-1:0] size_word,
                                  input logic [CFG_W-1:0] count_word);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BASE_ADDRESS;
        cfg_data <= base_word;
        @(posedge clk);
        pool_base = base_word[ADDR_W-1:0];
        cfg_index <= CFG_OBJECT_SIZE;
        cfg_data <= size_word;
        @(posedge clk);
        pool_size = size_word[SIZE_W-1:0];
        cfg_index <= CFG_OBJECT_COUNT;
        cfg_data <= count_word;
        @(posedge clk);
        pool_count = count_word[COUNT_W-1:0];
        cfg_wr_en <= 1'b0;
        cfg_data <= CFG_W'($urandom);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("result with nothing expected: status %0d address %h",
                       rsp.status, rsp.object_address);
                errors++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.object_address !== want.object_address)
                begin
                    $error("object_address: expected %h, got %h",
                           want.object_address, rsp.object_address);
                    errors++;
                end
                if (rsp.available_count !== want.available_count)
                begin
                    $error("available_count: expected %0d, got %0d",
                           want.available_count, rsp.available_count);
                    errors++;
                end
            end
        end
    end

    // empty stacks straight after reset
    task automatic test_before_init();
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_FREE, 32'h5);
        send_item(REQ_FREE, 32'h0);
        send_item(REQ_FREE, 32'h40);
        send_item(REQ_UNUSED, 32'hFFFF_FFFF);
    endtask

    // fill, drain and range checks on a three slot pool
    task automatic test_small_pool();
        configure_pool(32'h0000_1000, 32'h0000_0040, 32'h0000_0003);
        send_item(REQ_INIT, 32'h0);
        repeat (4) send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_FREE, 32'h0000_0FFF);
        send_item(REQ_FREE, 32'h0000_1081);
        send_item(REQ_FREE, 32'h0000_1080);
        send_item(REQ_FREE, 32'h0000_1001);
        send_item(REQ_FREE, 32'h0000_1040);
        send_item(REQ_FREE, 32'h0000_1040);
        send_item(REQ_ALLOC, 32'h0);
    endtask

    // wrapping addresses, count above depth, zero count and zero size
    task automatic test_extremes();
        configure_pool(32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(REQ_INIT, 32'h0);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_FREE, 32'hFFFF_FFFF);
        send_item(REQ_FREE, 32'hFFFF_FFFF);
        configure_pool(32'hFFFF_0000, 32'h0000_0010, 32'h0000_0000);
        send_item(REQ_INIT, 32'h0);
        send_item(REQ_FREE, 32'hFFFF_0000);
        send_item(REQ_ALLOC, 32'h0);
        configure_pool(32'h8000_0000, 32'h0000_0000, 32'h0000_0002);
        send_item(REQ_INIT, 32'h0);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_FREE, 32'h8000_0000);
        send_item(REQ_FREE, 32'h8000_0001);
    endtask

    task automatic test_random_phase(input int sender_idle);
        logic [CFG_W-1:0] base_word;
        logic [CFG_W-1:0] size_word;
        logic [CFG_W-1:0] count_word;
        logic [ADDR_W-1:0] addr;
        int seg;
        int k;
        int pick;
        int idx;
        idle_pct = sender_idle;
        for (seg = 0; seg < 3; seg++)
        begin
            case ($urandom_range(0, 4))
                0: base_word = 32'h0;
                1: base_word = 32'hFFFF_FFFF;
                2: base_word = 32'hFFFF_0000 + CFG_W'($urandom_range(0, 255));
                default: base_word = CFG_W'($urandom);
            endcase
            size_word = CFG_W'($urandom);
            case ($urandom_range(0, 5))
                0: size_word[SIZE_W-1:0] = 16'h0;
                1: size_word[SIZE_W-1:0] = 16'h1;
                2: size_word[SIZE_W-1:0] = 16'hFFFF;
                3: size_word[SIZE_W-1:0] = SIZE_W'($urandom);
                default: size_word[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 4096));
            endcase
            count_word = CFG_W'($urandom);
            case ($urandom_range(0, 7))
                0: count_word[COUNT_W-1:0] = 7'd0;
                1: count_word[COUNT_W-1:0] = 7'd64;
                2: count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(65, 127));
                3: count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(17, 63));
                default: count_word[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 16));
            endcase
            configure_pool(base_word, size_word, count_word);
            send_item(REQ_INIT, ADDR_W'($urandom));
            for (k = 0; k < 44; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_item(REQ_ALLOC, ADDR_W'($urandom));
                else if (pick < 75)
                begin
                    if (handed_out.size() != 0)
                    begin
                        idx = $urandom_range(0, handed_out.size() - 1);
                        addr = handed_out[idx];
                        handed_out.delete(idx);
                    end
                    else
                        addr = pick_pool_addr();
                    send_item(REQ_FREE, addr);
                end
                else if (pick < 86)
                    send_item(REQ_FREE, pick_pool_addr());
                else if (pick < 93)
                    send_item(REQ_FREE, ADDR_W'($urandom));
                else if (pick < 97)
                    send_item(REQ_INIT, ADDR_W'($urandom));
                else
                    send_item(REQ_UNUSED, ADDR_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_small_pool();
        test_extremes();
        test_random_phase(31);
        test_random_phase(88);
        test_random_phase(0);
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_rsps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> fixed_object_pool_allocator_top.f
hw/rtl/fopa_pkg.sv
hw/rtl/fopa_ctrl.sv
hw/rtl/fopa_dp.sv
hw/rtl/fixed_object_pool_allocator_top.sv
bench/fixed_object_pool_allocator_top_test.sv
